// ----- hdl/kthsl_pkg.sv -----
// Shared types, field widths and reset values for the k-th successor block.
package kthsl_pkg;

    localparam int NODE_W     = 10;
    localparam int STEP_W     = 61;
    localparam int COUNT_W    = 11;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam int MAX_NODES_DEF = 1024;
    localparam int LEVELS_DEF    = 61;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(1);
    localparam logic [STEP_W-1:0]  MAX_STEPS_RST  = STEP_W'(1) << 60;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_INDEX  = 2'd1,
        ST_OVER_LIMIT = 2'd2,
        ST_NOT_BUILT  = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 1'b1;

endpackage

// ----- hdl/kthsl_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module kthsl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- hdl/kth_successor_binary_lifting.sv -----
// K-th successor engine: successor table load, doubling-level build and query walk.
//
// Input stream beats carry a command in tuser and the node, successor and step
// count in tdata. Every beat yields exactly one result beat: status in tuser and
// the reached node in tdata (zero unless a query succeeds).
// A load, a rejected item or an unused command completes at the accept edge,
// where the result register loads.
// A query walks the levels from the lowest upwards, one level per cycle when the
// step bit is clear; when it is set the walk passes through S_QWAIT to take the
// registered table read data. A build fills the levels above level zero in turn
// for each active node: every entry needs two dependent reads of the table
// memory through its single read port.
// The block takes no input beat while a build or query is in progress, nor while
// a result waits in the output register and the receiver stalls; a stalled result
// holds its value until taken. Configuration writes are taken only while idle,
// an input beat waits while one is offered, and each one clears the built mark.
// Reset returns node_count to 1, max_steps to 2^60 and clears the built mark;
// the table memory is not cleared and entries are undefined until loaded.
module kth_successor_binary_lifting
    import kthsl_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int LEVELS    = LEVELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input beat: tdata = node_index[9:0], next_node[19:10], steps[80:20]
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser = command[1:0]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    // Result beat: tdata = result_node[9:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser = status[1:0]
    output logic [STATUS_W-1:0]   o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LEVEL_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVL_CW   = $clog2(LEVELS + 1);
    localparam int ACT_W    = ($clog2(MAX_NODES + 1) > COUNT_W) ?
                              $clog2(MAX_NODES + 1) : COUNT_W;
    localparam int RAM_DEPTH = LEVELS * (2 ** NODE_AW);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BSTART,
        S_BMID,
        S_BVAL,
        S_QSCAN,
        S_QWAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_built;
    logic [COUNT_W-1:0]  r_node_count;
    logic [STEP_W-1:0]   r_max_steps;
    logic                r_out_valid;
    logic [NODE_W-1:0]   r_out_node;
    t_status             r_out_status;
    logic [NODE_W-1:0]   r_p;
    logic [STEP_W-1:0]   r_rem;
    logic [LVL_CW-1:0]   r_lvl;
    logic [ACT_W-1:0]    r_j;

    logic [NODE_W-1:0]   in_node;
    logic [NODE_W-1:0]   in_next;
    logic [STEP_W-1:0]   in_steps;
    t_cmd                in_cmd;
    logic [ACT_W-1:0]    cnt_ext;
    logic [ACT_W-1:0]    active_cnt;
    logic                node_bad;
    logic                next_bad;
    logic                out_free;
    logic                in_accept;
    logic                cfg_accept;
    logic [NODE_W-1:0]   rd_data;
    logic [NODE_W-1:0]   rd_node;
    logic [RAM_AW-1:0]   rd_addr;
    logic                wr_en;
    logic [RAM_AW-1:0]   wr_addr;
    logic [NODE_W-1:0]   wr_data;
    logic [LVL_CW-1:0]   lvl_below;
    logic [ACT_W-1:0]    j_next;
    logic [STEP_W-1:0]   rem_next;
    logic [LVL_CW-1:0]   lvl_next;
    logic                last_level;

    function automatic logic [RAM_AW-1:0] f_addr(input logic [LVL_CW-1:0] lvl,
                                                 input logic [ACT_W-1:0] node);
        logic [LEVEL_AW+NODE_AW-1:0] a;
        a = {lvl[LEVEL_AW-1:0], node[NODE_AW-1:0]};
        return RAM_AW'(a);
    endfunction

    assign in_node  = i_s_axis_tdata[NODE_W-1:0];
    assign in_next  = i_s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_steps = i_s_axis_tdata[2*NODE_W+STEP_W-1:2*NODE_W];
    assign in_cmd   = t_cmd'(i_s_axis_tuser);

    assign cnt_ext    = ACT_W'(r_node_count);
    assign active_cnt = (cnt_ext > ACT_W'(MAX_NODES)) ? ACT_W'(MAX_NODES) : cnt_ext;
    assign node_bad   = ACT_W'(in_node) >= active_cnt;
    assign next_bad   = ACT_W'(in_next) >= active_cnt;

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free && !i_cfg_valid;
    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_accept = i_cfg_valid && o_cfg_ready;

    assign rd_node    = (ACT_W'(rd_data) >= ACT_W'(MAX_NODES)) ? '0 : rd_data;
    assign lvl_below  = r_lvl - LVL_CW'(1);
    assign j_next     = r_j + ACT_W'(1);
    assign rem_next   = r_rem >> 1;
    assign lvl_next   = r_lvl + LVL_CW'(1);
    assign last_level = (rem_next == '0) || (lvl_next == LVL_CW'(LEVELS));

    always_comb begin
        case (r_state)
            S_BSTART: rd_addr = f_addr(lvl_below, r_j);
            S_BMID:   rd_addr = f_addr(lvl_below, ACT_W'(rd_node));
            S_BVAL:   rd_addr = f_addr(lvl_below, j_next);
            S_QSCAN:  rd_addr = f_addr(r_lvl, ACT_W'(r_p));
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        if (r_state == S_BVAL) begin
            wr_en   = 1'b1;
            wr_addr = f_addr(r_lvl, r_j);
            wr_data = rd_data;
        end else begin
            wr_en   = in_accept && (in_cmd == CMD_LOAD) && !node_bad && !next_bad;
            wr_addr = f_addr('0, ACT_W'(in_node));
            wr_data = in_next;
        end
    end

    kthsl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_built      <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_max_steps  <= MAX_STEPS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_accept) begin
                r_built <= 1'b0;
                case (i_cfg_index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data;
                    default:        r_node_count <= r_node_count;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_out_status <= ST_OK;
                        r_out_node   <= '0;
                        case (in_cmd)
                            CMD_LOAD: begin
                                r_out_valid <= 1'b1;
                                if (node_bad || next_bad) begin
                                    r_out_status <= ST_BAD_INDEX;
                                end else begin
                                    r_built <= 1'b0;
                                end
                            end
                            CMD_BUILD: begin
                                r_p   <= '0;
                                r_j   <= '0;
                                r_lvl <= LVL_CW'(1);
                                r_rem <= r_max_steps >> 1;
                                if ((r_max_steps >> 1) == '0 || LEVELS == 1 ||
                                    active_cnt == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_BSTART;
                                end
                            end
                            CMD_QUERY: begin
                                if (node_bad) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_BAD_INDEX;
                                end else if (in_steps > r_max_steps) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_OVER_LIMIT;
                                end else if (!r_built) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_NOT_BUILT;
                                end else begin
                                    r_p     <= in_node;
                                    r_rem   <= in_steps;
                                    r_lvl   <= '0;
                                    r_state <= S_QSCAN;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_BSTART: begin
                    r_state <= S_BMID;
                end
                S_BMID: begin
                    r_state <= S_BVAL;
                end
                S_BVAL: begin
                    if (j_next < active_cnt) begin
                        r_j     <= j_next;
                        r_state <= S_BMID;
                    end else begin
                        r_j   <= '0;
                        r_lvl <= lvl_next;
                        r_rem <= rem_next;
                        if (last_level) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_BSTART;
                        end
                    end
                end
                S_QSCAN: begin
                    if (r_rem == '0 || r_lvl == LVL_CW'(LEVELS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_rem <= rem_next;
                        r_lvl <= lvl_next;
                        if (r_rem[0]) begin
                            r_state <= S_QWAIT;
                        end
                    end
                end
                S_QWAIT: begin
                    r_p     <= rd_node;
                    r_state <= S_QSCAN;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_node   <= r_p;
                        r_built      <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_node);
    assign o_m_axis_tuser  = r_out_status;

    a_query_needs_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QSCAN || r_state == S_QWAIT) |-> r_built)
        else $error("query walk running on an unbuilt table");

    a_failed_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("non-zero node on a failed result");

    a_build_not_level0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BVAL) |-> (r_lvl != '0))
        else $error("build writing into level zero");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWAIT) |-> (r_lvl <= LVL_CW'(LEVELS) && r_lvl != '0))
        else $error("query level counter out of range");

endmodule

// ----- sim/tb_kth_successor_binary_lifting.sv -----
// Self-checking testbench for the k-th successor engine: table loads, builds and queries.
module tb_kth_successor_binary_lifting
    import kthsl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = MAX_NODES_DEF;
    localparam int DEPTH = LEVELS_DEF;
    localparam logic [STEP_W-1:0] ALL_STEPS = {STEP_W{1'b1}};

    typedef struct {
        t_cmd               cmd;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  succ;
        logic [STEP_W-1:0]  steps;
    } t_req;

    typedef struct {
        t_status            status;
        logic [NODE_W-1:0]  node;
    } t_answer;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [STEP_W-1:0]     cfg_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_ready;

    // Shadow of the block: configuration, built mark and the doubling levels.
    logic [COUNT_W-1:0]    cfg_nodes = NODE_COUNT_RST;
    logic [STEP_W-1:0]     step_cap = MAX_STEPS_RST;
    bit                    table_ready = 1'b0;
    logic [NODE_W-1:0]     lift_table [DEPTH][NODES];

    t_req                  pending_reqs [$];
    t_answer               answers_due [$];
    int                    fault_count = 0;
    int                    reqs_queued = 0;
    bit                    no_gaps = 1'b0;
    int                    stall_asks = 0;

    kth_successor_binary_lifting u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int nodes_in_use();
        return (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
    endfunction

    function automatic int lift_levels();
        int n;
        logic [STEP_W-1:0] v;
        n = 0;
        v = step_cap;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return (n > DEPTH) ? DEPTH : n;
    endfunction

    function automatic t_answer apply_command(t_req r);
        t_answer a;
        int n;
        int lv;
        int i;
        int j;
        logic [NODE_W-1:0] p;
        a.status = ST_OK;
        a.node = '0;
        n = nodes_in_use();
        lv = lift_levels();
        case (r.cmd)
            CMD_LOAD: begin
                if (r.node >= n || r.succ >= n) begin
                    a.status = ST_BAD_INDEX;
                end else begin
                    lift_table[0][r.node] = r.succ;
                    table_ready = 1'b0;
                end
            end
            CMD_BUILD: begin
                for (i = 1; i < lv; i++) begin
                    for (j = 0; j < n; j++) begin
                        lift_table[i][j] = lift_table[i-1][lift_table[i-1][j]];
                    end
                end
                table_ready = 1'b1;
            end
            CMD_QUERY: begin
                if (r.node >= n) begin
                    a.status = ST_BAD_INDEX;
                end else if (r.steps > step_cap) begin
                    a.status = ST_OVER_LIMIT;
                end else if (!table_ready) begin
                    a.status = ST_NOT_BUILT;
                end else begin
                    p = r.node;
                    for (i = 0; i < lv; i++) begin
                        if (r.steps[i]) begin
                            p = lift_table[i][p];
                        end
                    end
                    a.node = p;
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    // Sender: presents queued requests and records the answer due for each accepted beat.
    always @(posedge clk) begin
        t_req cur;
        t_req nxt;
        bit taken;
        bit gap;
        if (rst_n) begin
            taken = s_valid && s_ready;
            if (taken) begin
                answers_due.push_back(apply_command(cur));
            end
            if (!s_valid || taken) begin
                gap = !no_gaps && ($urandom_range(99) < 7);
                if (pending_reqs.size() != 0 && !gap) begin
                    nxt = pending_reqs.pop_front();
                    cur = nxt;
                    s_valid <= 1'b1;
                    s_tdata <= IN_DATA_W'({nxt.steps, nxt.succ, nxt.node});
                    s_tuser <= nxt.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and applies random and long back-pressure.
    always @(posedge clk) begin
        t_answer want;
        int stall_seen;
        int stall_left;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%0t: result beat with nothing due: status %0d tdata %0h",
                                 $realtime, m_tuser, m_tdata);
                    end
                end else begin
                    want = answers_due.pop_front();
                    if (m_tuser != want.status || m_tdata != OUT_DATA_W'(want.node)) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("%0t: expected status %0d node %0d, got status %0d tdata %0d",
                                     $realtime, want.status, want.node, m_tuser, m_tdata);
                        end
                    end
                end
            end
            if (stall_seen != stall_asks) begin
                stall_seen = stall_asks;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_gaps || ($urandom_range(99) >= 7);
            end
        end
    end

    function automatic logic [STEP_W-1:0] rand_steps();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[STEP_W-1:0];
    endfunction

    function automatic logic [STEP_W-1:0] pick_steps();
        logic [STEP_W-1:0] s;
        case ($urandom_range(9))
            0: s = step_cap;
            1: s = step_cap + 1'b1;
            2: s = rand_steps();
            3: s = '0;
            default: begin
                s = rand_steps() >> $urandom_range(STEP_W - 1);
                while (s > step_cap) begin
                    s = s >> 1;
                end
            end
        endcase
        return s;
    endfunction

    task automatic push_req(t_cmd c, int node, int succ, logic [STEP_W-1:0] steps);
        t_req r;
        r.cmd = c;
        r.node = NODE_W'(node);
        r.succ = NODE_W'(succ);
        r.steps = steps;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Stray beats that never build: rejected loads, early queries and unused commands.
    task automatic push_noise();
        case ($urandom_range(2))
            0: push_req(CMD_LOAD, $urandom_range(NODES - 1),
                        $urandom_range(nodes_in_use(), NODES - 1), rand_steps());
            1: push_req(CMD_QUERY, $urandom_range(NODES - 1), 0, rand_steps());
            default: push_req(CMD_NONE, $urandom_range(NODES - 1),
                              $urandom_range(NODES - 1), rand_steps());
        endcase
    endtask

    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_reqs.size() != 0 || s_valid || answers_due.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT) begin
            cfg_nodes = value[COUNT_W-1:0];
        end else begin
            step_cap = value;
        end
        table_ready = 1'b0;
    endtask

    task automatic set_config(int nodes, logic [STEP_W-1:0] cap);
        wait_idle();
        if ($urandom_range(1)) begin
            cfg_write(CFG_NODE_COUNT, STEP_W'(nodes));
            cfg_write(CFG_MAX_STEPS, cap);
        end else begin
            cfg_write(CFG_MAX_STEPS, cap);
            cfg_write(CFG_NODE_COUNT, STEP_W'(nodes));
        end
    endtask

    // Every node in use gets a successor inside the range, so a build reads only loaded entries.
    task automatic load_every_node();
        int order [$];
        int k;
        int t;
        int a;
        for (k = 0; k < nodes_in_use(); k++) begin
            order.push_back(k);
        end
        for (k = order.size() - 1; k > 0; k--) begin
            a = $urandom_range(k);
            t = order[k];
            order[k] = order[a];
            order[a] = t;
        end
        foreach (order[k]) begin
            if ($urandom_range(99) < 10) begin
                push_noise();
            end
            push_req(CMD_LOAD, order[k], $urandom_range(nodes_in_use() - 1), rand_steps());
        end
    endtask

    task automatic random_phase(int ph);
        int pick;
        int nodes;
        int n;
        int k;
        logic [STEP_W-1:0] cap;
        wait_idle();
        no_gaps = (ph == 3 || ph == 4);
        pick = $urandom_range(99);
        if (pick < 60) nodes = $urandom_range(2, 16);
        else if (pick < 78) nodes = $urandom_range(17, 128);
        else if (pick < 84) nodes = 1;
        else if (pick < 90) nodes = 0;
        else nodes = $urandom_range(NODES, 2047);
        pick = $urandom_range(99);
        if (pick < 30) cap = rand_steps() >> $urandom_range(52, STEP_W - 1);
        else if (pick < 45) cap = MAX_STEPS_RST;
        else if (pick < 55) cap = ALL_STEPS;
        else if (pick < 62) cap = '0;
        else cap = rand_steps() >> $urandom_range(STEP_W - 1);
        set_config(nodes, cap);
        if (ph % 8 == 1) begin
            stall_asks++;
        end
        n = nodes_in_use();
        if (n >= 1 && n <= 128) begin
            load_every_node();
            push_req(CMD_BUILD, $urandom_range(NODES - 1), $urandom_range(NODES - 1),
                     rand_steps());
            for (k = $urandom_range(20, 40); k > 0; k--) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    push_req(CMD_QUERY, $urandom_range(n - 1), $urandom_range(NODES - 1),
                             pick_steps());
                end else if (pick < 82) begin
                    push_req(CMD_QUERY, $urandom_range(n, NODES - 1), 0, pick_steps());
                end else if (pick < 92) begin
                    push_noise();
                end else begin
                    if (pick < 97) begin
                        push_req(CMD_LOAD, $urandom_range(n - 1), $urandom_range(n - 1),
                                 rand_steps());
                    end
                    if ($urandom_range(1)) begin
                        push_req(CMD_BUILD, 0, 0, rand_steps());
                    end
                end
            end
        end else begin
            for (k = 0; k < 40; k++) begin
                case ($urandom_range(3))
                    0: push_req(CMD_LOAD, $urandom_range(NODES - 1), $urandom_range(NODES - 1),
                                rand_steps());
                    1: push_req(CMD_QUERY, $urandom_range(NODES - 1), 0, pick_steps());
                    2: push_noise();
                    default: begin
                        if (n == 0) push_req(CMD_BUILD, $urandom_range(NODES - 1), 0,
                                             rand_steps());
                        else push_req(CMD_QUERY, $urandom_range(NODES - 1), 0, rand_steps());
                    end
                endcase
            end
        end
    endtask

    initial begin
        int ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // One node after reset: rejected loads, the limit edge and the clearing of the built mark.
        push_req(CMD_QUERY, 0, 0, '0);
        push_req(CMD_LOAD, 0, 0, '0);
        push_req(CMD_LOAD, 1, 0, '0);
        push_req(CMD_LOAD, 0, NODES - 1, '0);
        push_req(CMD_BUILD, 0, 0, '0);
        push_req(CMD_QUERY, 0, 0, MAX_STEPS_RST);
        push_req(CMD_QUERY, 0, 0, MAX_STEPS_RST + 1'b1);
        push_req(CMD_QUERY, 0, 0, ALL_STEPS);
        push_req(CMD_QUERY, NODES - 1, NODES - 1, '0);
        push_req(CMD_QUERY, 0, 0, '0);
        push_req(CMD_NONE, NODES - 1, NODES - 1, ALL_STEPS);
        push_req(CMD_LOAD, 0, 0, '0);
        push_req(CMD_QUERY, 0, 0, STEP_W'(1));

        // A count above the table size acts as the full table.
        set_config(2047, ALL_STEPS);
        push_req(CMD_LOAD, NODES - 1, NODES - 1, ALL_STEPS);
        push_req(CMD_QUERY, NODES - 1, 0, ALL_STEPS);

        // A count of zero rejects every index.
        set_config(0, ALL_STEPS);
        push_req(CMD_LOAD, 0, 0, '0);
        push_req(CMD_BUILD, 0, 0, '0);
        push_req(CMD_QUERY, 0, 0, '0);

        // A limit of zero builds no levels and allows only zero steps.
        set_config(4, '0);
        push_req(CMD_LOAD, 0, 1, '0);
        push_req(CMD_LOAD, 1, 2, '0);
        push_req(CMD_LOAD, 2, 3, '0);
        push_req(CMD_LOAD, 3, 0, '0);
        push_req(CMD_BUILD, 0, 0, '0);
        push_req(CMD_QUERY, 2, 0, '0);
        push_req(CMD_QUERY, 1, 0, STEP_W'(1));

        ph = 0;
        while (reqs_queued < 1150) begin
            random_phase(ph);
            ph++;
        end

        wait_idle();
        no_gaps = 1'b0;
        repeat (300) @(posedge clk);
        fault_count += answers_due.size();
        if (fault_count == 0) begin
            $display("tb_kth_successor_binary_lifting: PASS");
        end else begin
            $display("tb_kth_successor_binary_lifting: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_kth_successor_binary_lifting: FAIL");
        $finish;
    end

endmodule
